FILE: rtl/selective_repeat_receiver_assert.svh
// ----------------------------------------------------------------------------
// Selective-repeat receiver assertion macros
// Concurrent assertion shorthands used by the receiver datapath.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define SRR_ASSERT_IMP(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
`define SRR_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRR_ASSERT_IMP(name, ck, rn, ante, cons, msg)
`define SRR_ASSERT_NEXT(name, ck, rn, ante, cons, msg)
`endif
`endif

FILE: rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// Selective-repeat receiver package
// Payload types, controller states and commands, default window and message sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package srr_pkg;

    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 11;
    localparam int REF_W  = 32;
    localparam int TIME_W = 32;

    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int MAX_MESSAGE_DEF  = 1024;

    localparam logic [LEN_W-1:0] MAX_DELIVERY_LEN_RST = LEN_W'(1024);

    typedef logic [LEN_W-1:0] cfg_data_t;

    typedef struct packed {
        logic              opcode;
        logic [SEQ_W-1:0]  seq_num;
        logic              corrupted;
        logic [LEN_W-1:0]  msg_len;
        logic [REF_W-1:0]  payload_ref;
        logic [TIME_W-1:0] send_time;
    } pkt_t;

    typedef struct packed {
        logic              ack_valid;
        logic [SEQ_W-1:0]  ack_seq;
        logic [TIME_W-1:0] ack_time;
        logic              deliver_valid;
        logic [LEN_W-1:0]  deliver_len;
        logic [REF_W-1:0]  deliver_ref;
        logic              overflow;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_FETCH,
        ST_LOAD
    } srr_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;
        logic update;
        logic fetch;
        logic load;
    } srr_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
    } srr_status_t;

endpackage

`default_nettype wire

FILE: rtl/srr_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload of a configurable type.
// ----------------------------------------------------------------------------
`default_nettype none

interface srr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/selective_repeat_receiver.sv
// Sequence: a request is accepted, updates the window, fetches the head slot and
// loads its result into the output register once that register is free.
// Requests: a new request is taken only after the controller's capture,
// update, fetch and load steps for the last one; a waiting result stalls it.
// Reset: rst_n clears the window, empties all slots and sets the limit to 1024.
// ----------------------------------------------------------------------------
// Selective-repeat receiver
// Receive window with ACK generation and in-order delivery of stored packets.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_receiver #(
    parameter int WINDOW_DEPTH = srr_pkg::WINDOW_DEPTH_DEF,
    parameter int MAX_MESSAGE  = srr_pkg::MAX_MESSAGE_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    srr_stream_if.sink   pkt_in,
    srr_stream_if.sink   cfg,
    srr_stream_if.source result
);
    import srr_pkg::*;

    srr_cmd_t    cmd;
    srr_status_t status;
    logic        in_ready;

    assign pkt_in.ready = in_ready;

    srr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pkt_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    srr_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_MESSAGE  (MAX_MESSAGE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .pkt_item (pkt_in.data),
        .cfg      (cfg),
        .result   (result)
    );

endmodule

`default_nettype wire

FILE: rtl/srr_ctrl.sv
// ----------------------------------------------------------------------------
// Selective-repeat receiver controller
// Sequences each request through window update, head fetch and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module srr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire srr_pkg::srr_status_t status,
    output srr_pkg::srr_cmd_t        cmd
);
    import srr_pkg::*;

    srr_state_t state_reg;
    srr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Wait here until the output register can take the result.
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/srr_datapath.sv
// ----------------------------------------------------------------------------
// Selective-repeat receiver datapath
// Window state, slot memories, ACK decision and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "selective_repeat_receiver_assert.svh"

module srr_datapath #(
    parameter int WINDOW_DEPTH = srr_pkg::WINDOW_DEPTH_DEF,
    parameter int MAX_MESSAGE  = srr_pkg::MAX_MESSAGE_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire srr_pkg::srr_cmd_t   cmd,
    output srr_pkg::srr_status_t     status,
    input  wire srr_pkg::pkt_t       pkt_item,
    srr_stream_if.sink               cfg,
    srr_stream_if.source             result
);
    import srr_pkg::*;

    localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int IDXP_W = IDX_W + 1;

    localparam logic [IDXP_W-1:0] DEPTH_P   = IDXP_W'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [SEQ_W-1:0]  DEPTH_SEQ = SEQ_W'(WINDOW_DEPTH);
    localparam logic [15:0]       MAX_MSG   = 16'(MAX_MESSAGE);

    pkt_t                    item_reg;
    logic [SEQ_W-1:0]        expected_seq_reg;
    logic [SEQ_W-1:0]        expected_seq_next;
    logic [IDX_W-1:0]        head_idx_reg;
    logic [IDX_W-1:0]        head_idx_next;
    logic [WINDOW_DEPTH-1:0] slot_full_reg;
    logic [WINDOW_DEPTH-1:0] slot_full_next;
    logic [LEN_W-1:0]        max_len_reg;
    logic [LEN_W-1:0]        max_len_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    res_t                    res_reg;

    logic                    ack_valid_reg;
    logic [SEQ_W-1:0]        ack_seq_reg;
    logic [TIME_W-1:0]       ack_time_reg;
    logic                    dlv_reg;
    logic [LEN_W-1:0]        rd_len_reg;
    logic [REF_W-1:0]        rd_ref_reg;

    logic [LEN_W-1:0]        len_mem [WINDOW_DEPTH];
    logic [REF_W-1:0]        ref_mem [WINDOW_DEPTH];

    logic [SEQ_W-1:0]        seq_diff;
    logic                    is_pkt;
    logic                    is_below;
    logic                    in_win;
    logic [IDXP_W-1:0]       slot_sum;
    logic [IDXP_W-1:0]       slot_wrap;
    logic [IDX_W-1:0]        slot_idx;
    logic                    do_store;
    logic                    do_ack;
    logic [LEN_W-1:0]        len_sat;
    logic                    commit_dlv;

    // The packet slot is found from the head index and the distance to the
    // expected number, which is below the window depth inside the window.
    always_comb
    begin
        seq_diff  = item_reg.seq_num - expected_seq_reg;
        is_pkt    = item_reg.opcode && !item_reg.corrupted;
        is_below  = item_reg.seq_num < expected_seq_reg;
        in_win    = !is_below && (seq_diff < DEPTH_SEQ);
        slot_sum  = {1'b0, head_idx_reg} + {1'b0, seq_diff[IDX_W-1:0]};
        slot_wrap = slot_sum - DEPTH_P;
        slot_idx  = (slot_sum >= DEPTH_P) ? slot_wrap[IDX_W-1:0] : slot_sum[IDX_W-1:0];
        do_store  = is_pkt && in_win && !slot_full_reg[slot_idx];
        do_ack    = is_pkt && (is_below || do_store);
        len_sat   = (16'(item_reg.msg_len) > MAX_MSG) ? MAX_MSG[LEN_W-1:0]
                                                      : item_reg.msg_len;
    end

    assign commit_dlv      = cmd.load && dlv_reg;
    assign status.out_free = !res_valid_reg || result.ready;
    assign cfg.ready       = 1'b1;
    assign result.valid    = res_valid_reg;
    assign result.data     = res_reg;

    always_comb
    begin
        slot_full_next    = slot_full_reg;
        expected_seq_next = expected_seq_reg;
        head_idx_next     = head_idx_reg;
        max_len_next      = max_len_reg;
        res_valid_next    = res_valid_reg;

        if (cmd.update && do_store)
        begin
            slot_full_next[slot_idx] = 1'b1;
        end
        if (commit_dlv)
        begin
            slot_full_next[head_idx_reg] = 1'b0;
            expected_seq_next            = expected_seq_reg + SEQ_W'(1);
            // The head index wraps after the last slot and restarts with the sequence space.
            if ((expected_seq_reg == '1) || (head_idx_reg == LAST_IDX))
            begin
                head_idx_next = '0;
            end
            else
            begin
                head_idx_next = head_idx_reg + IDX_W'(1);
            end
        end
        if (cfg.valid)
        begin
            max_len_next = cfg.data;
        end
        if (cmd.load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_full_reg    <= '0;
            expected_seq_reg <= '0;
            head_idx_reg     <= '0;
            max_len_reg      <= MAX_DELIVERY_LEN_RST;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            slot_full_reg    <= slot_full_next;
            expected_seq_reg <= expected_seq_next;
            head_idx_reg     <= head_idx_next;
            max_len_reg      <= max_len_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= pkt_item;
        end
        if (cmd.update)
        begin
            ack_valid_reg <= do_ack;
            ack_seq_reg   <= do_ack ? item_reg.seq_num : '0;
            ack_time_reg  <= do_ack ? item_reg.send_time : '0;
        end
        if (cmd.fetch)
        begin
            dlv_reg <= slot_full_reg[head_idx_reg];
        end
        if (cmd.load)
        begin
            res_reg.ack_valid     <= ack_valid_reg;
            res_reg.ack_seq       <= ack_seq_reg;
            res_reg.ack_time      <= ack_time_reg;
            res_reg.deliver_valid <= dlv_reg;
            res_reg.deliver_len   <= dlv_reg ? rd_len_reg : '0;
            res_reg.deliver_ref   <= dlv_reg ? rd_ref_reg : '0;
            res_reg.overflow      <= dlv_reg && (rd_len_reg > max_len_reg);
        end
    end

    // Slot memories: written on store, head entry read with registered data.
    always_ff @(posedge clk)
    begin
        if (cmd.update && do_store)
        begin
            len_mem[slot_idx] <= len_sat;
            ref_mem[slot_idx] <= item_reg.payload_ref;
        end
        if (cmd.fetch)
        begin
            rd_len_reg <= len_mem[head_idx_reg];
            rd_ref_reg <= ref_mem[head_idx_reg];
        end
    end

    `SRR_ASSERT_IMP(a_head_in_range, clk, rst_n, 1'b1, head_idx_reg <= LAST_IDX,
                    "head index past window")
    `SRR_ASSERT_NEXT(a_advance_on_deliver, clk, rst_n, commit_dlv,
                     expected_seq_reg == $past(expected_seq_reg) + SEQ_W'(1),
                     "expected number did not advance")
    `SRR_ASSERT_NEXT(a_head_freed, clk, rst_n, commit_dlv,
                     !slot_full_reg[$past(head_idx_reg)], "delivered slot still full")
    `SRR_ASSERT_NEXT(a_hold_without_deliver, clk, rst_n, cmd.load && !dlv_reg,
                     $stable(expected_seq_reg), "expected number moved without delivery")

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Selective-repeat receiver testbench
// Drives packet and poll requests through the receive window and predicts
// every ACK and delivery with a local window model. Changes the delivery
// limit between phases, and varies idling on both sides. One phase holds
// off the result side long enough to stall the input.
// ----------------------------------------------------------------------------

module tb;

    import srr_pkg::*;

    localparam int WIN     = WINDOW_DEPTH_DEF;
    localparam int MAX_MSG = MAX_MESSAGE_DEF;

    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_PACKET = 1'b1;

    // The window model: it tracks what the block should hold and queues the
    // result that each accepted request must produce.
    class window_scoreboard;
        logic [SEQ_W-1:0] next_seq;
        bit               slot_full [WIN];
        logic [LEN_W-1:0] slot_len  [WIN];
        logic [REF_W-1:0] slot_ref  [WIN];
        cfg_data_t        limit;
        res_t             expected_results [$];
        int               failures;

        function new();
            next_seq = '0;
            limit    = MAX_DELIVERY_LEN_RST;
            failures = 0;
            for (int i = 0; i < WIN; i++)
            begin
                slot_full[i] = 1'b0;
                slot_len[i]  = '0;
                slot_ref[i]  = '0;
            end
        endfunction

        function void set_limit(cfg_data_t v);
            limit = v;
        endfunction

        function void note_request(pkt_t p);
            res_t             r;
            logic [LEN_W-1:0] len;
            int               idx;
            int               head;
            r   = '0;
            len = (p.msg_len > LEN_W'(MAX_MSG)) ? LEN_W'(MAX_MSG) : p.msg_len;
            if (p.opcode == OP_PACKET && !p.corrupted)
            begin
                if (p.seq_num < next_seq)
                begin
                    r.ack_valid = 1'b1;
                    r.ack_seq   = p.seq_num;
                    r.ack_time  = p.send_time;
                end
                else if ((p.seq_num - next_seq) < SEQ_W'(WIN))
                begin
                    idx = int'(p.seq_num % SEQ_W'(WIN));
                    if (!slot_full[idx])
                    begin
                        slot_full[idx] = 1'b1;
                        slot_len[idx]  = len;
                        slot_ref[idx]  = p.payload_ref;
                        r.ack_valid    = 1'b1;
                        r.ack_seq      = p.seq_num;
                        r.ack_time     = p.send_time;
                    end
                end
            end
            head = int'(next_seq % SEQ_W'(WIN));
            if (slot_full[head])
            begin
                r.deliver_valid = 1'b1;
                r.deliver_len   = slot_len[head];
                r.deliver_ref   = slot_ref[head];
                r.overflow      = (slot_len[head] > limit);
                slot_full[head] = 1'b0;
                next_seq        = next_seq + 1'b1;
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t want;
            bit   bad;
            if (expected_results.size() == 0)
            begin
                if (failures < 10)
                    $display("unexpected result: ack %0b seq %h dlv %0b len %0d ref %h",
                             got.ack_valid, got.ack_seq, got.deliver_valid,
                             got.deliver_len, got.deliver_ref);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            bad  = (got.ack_valid !== want.ack_valid) || (got.ack_seq !== want.ack_seq) ||
                   (got.ack_time !== want.ack_time) ||
                   (got.deliver_valid !== want.deliver_valid) ||
                   (got.deliver_len !== want.deliver_len) ||
                   (got.deliver_ref !== want.deliver_ref) ||
                   (got.overflow !== want.overflow);
            if (bad)
            begin
                if (failures < 10)
                begin
                    $display("mismatch expected: ack %0b seq %h time %h dlv %0b len %0d ref %h ovf %0b",
                             want.ack_valid, want.ack_seq, want.ack_time, want.deliver_valid,
                             want.deliver_len, want.deliver_ref, want.overflow);
                    $display("         actual:   ack %0b seq %h time %h dlv %0b len %0d ref %h ovf %0b",
                             got.ack_valid, got.ack_seq, got.ack_time, got.deliver_valid,
                             got.deliver_len, got.deliver_ref, got.overflow);
                end
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    srr_stream_if #(.payload_t(pkt_t))      pkt_if ();
    srr_stream_if #(.payload_t(cfg_data_t)) cfg_if ();
    srr_stream_if #(.payload_t(res_t))      res_if ();

    selective_repeat_receiver #(
        .WINDOW_DEPTH (WIN),
        .MAX_MESSAGE  (MAX_MSG)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt_in (pkt_if),
        .cfg    (cfg_if),
        .result (res_if)
    );

    window_scoreboard sb;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("selective_repeat_receiver regression: fail");
        $finish;
    end

    // Result side: random idling, plus a long hold-off when requested.
    initial
    begin
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.data);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input pkt_t p);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pkt_if.valid <= 1'b0;
            @(negedge clk);
        end
        pkt_if.valid <= 1'b1;
        pkt_if.data  <= p;
        do
            @(posedge clk);
        while (!pkt_if.ready);
        sb.note_request(p);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic op, input logic [SEQ_W-1:0] seq,
                               input logic bad, input logic [LEN_W-1:0] len,
                               input logic [REF_W-1:0] pref, input logic [TIME_W-1:0] stime);
        pkt_t p;
        p.opcode      = op;
        p.seq_num     = seq;
        p.corrupted   = bad;
        p.msg_len     = len;
        p.payload_ref = pref;
        p.send_time   = stime;
        send_request(p);
    endtask

    // Waits until the block is idle, then writes the delivery limit.
    task automatic write_limit(input cfg_data_t v);
        pkt_if.valid <= 1'b0;
        while (sb.expected_results.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.set_limit(v);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic pkt_t random_request();
        pkt_t p;
        int   pick;
        int   lsel;
        pick          = $urandom_range(99);
        p.opcode      = OP_PACKET;
        p.corrupted   = ($urandom_range(99) < 4);
        p.payload_ref = $urandom;
        p.send_time   = $urandom;
        // Most requests land near the window so that storing and delivery dominate.
        p.seq_num     = sb.next_seq + SEQ_W'($urandom_range(13)) - SEQ_W'(4);
        if (pick < 10)
        begin
            p.opcode  = OP_POLL;
            p.seq_num = $urandom;
        end
        else if (pick < 18)
            p.corrupted = 1'b1;
        else if (pick < 25)
            p.seq_num = $urandom;
        else if (pick < 30)
            p.seq_num = 32'hFFFF_FFF0 + SEQ_W'($urandom_range(15));
        lsel = $urandom_range(99);
        if (lsel < 5)
            p.msg_len = LEN_W'($urandom_range(2047, MAX_MSG + 1));
        else if (lsel < 10)
            p.msg_len = LEN_W'(MAX_MSG);
        else if (lsel < 14)
            p.msg_len = '0;
        else
            p.msg_len = LEN_W'($urandom_range(MAX_MSG));
        return p;
    endfunction

    task automatic run_phase(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
            send_request(random_request());
    endtask

    initial
    begin
        sb           = new();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_left    = 0;
        rst_n        = 1'b0;
        pkt_if.valid = 1'b0;
        pkt_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, run at the reset limit first.
        send_fields(OP_POLL,   32'd0,         1'b0, 11'd5,    32'h1234_5678, 32'h9ABC_DEF0);
        send_fields(OP_PACKET, 32'd0,         1'b0, 11'd0,    32'h0000_0000, 32'h0000_0000);
        send_fields(OP_PACKET, 32'd1,         1'b1, 11'd10,   32'h1111_1111, 32'h2222_2222);
        write_limit(cfg_data_t'(1023));
        send_fields(OP_PACKET, 32'd3,         1'b0, 11'd1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // An overlong length is stored saturated.
        send_fields(OP_PACKET, 32'd2,         1'b0, 11'd2047, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_fields(OP_PACKET, 32'd3,         1'b0, 11'd7,    32'h0BAD_0BAD, 32'h0000_0003);
        send_fields(OP_PACKET, 32'd9,         1'b0, 11'd8,    32'h0000_0009, 32'h0000_0009);
        send_fields(OP_PACKET, 32'hFFFF_FFFF, 1'b0, 11'd9,    32'hDEAD_BEEF, 32'hCAFE_F00D);
        send_fields(OP_PACKET, 32'd0,         1'b0, 11'd11,   32'h0000_0010, 32'h7777_0000);
        send_fields(OP_PACKET, 32'd1,         1'b0, 11'd1023, 32'h0000_0001, 32'h0000_0001);
        send_fields(OP_POLL,   32'hFFFF_FFFF, 1'b1, 11'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(OP_POLL,   32'd0,         1'b0, 11'd0,    32'd0,         32'd0);
        send_fields(OP_POLL,   32'd0,         1'b0, 11'd0,    32'd0,         32'd0);
        // Fill the whole window from the top down, then release it in order.
        for (int s = 11; s >= 5; s--)
            send_fields(OP_PACKET, SEQ_W'(s), 1'b0, LEN_W'(s * 100), REF_W'(s), TIME_W'(s));
        send_fields(OP_PACKET, 32'd12,        1'b0, 11'd12,   32'd12,        32'd12);
        send_fields(OP_PACKET, 32'd4,         1'b0, 11'd4,    32'd4,         32'd4);
        for (int k = 0; k < 4; k++)
            send_fields(OP_POLL, 32'd0, 1'b0, 11'd0, 32'd0, 32'd0);

        write_limit(cfg_data_t'(0));
        run_phase(220, 22, 68);

        write_limit(MAX_DELIVERY_LEN_RST);
        run_phase(220, 68, 22);

        write_limit(cfg_data_t'($urandom_range(1000, 24)));
        // The result side holds off while requests keep coming, so the block fills up.
        hold_left = 400;
        run_phase(210, 0, 0);
        pkt_if.valid <= 1'b0;

        while (sb.expected_results.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.expected_results.size() == 0)
            $display("selective_repeat_receiver regression: pass");
        else
            $display("selective_repeat_receiver regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/srr_pkg.sv
rtl/srr_stream_if.sv
rtl/srr_ctrl.sv
rtl/srr_datapath.sv
rtl/selective_repeat_receiver.sv
sim/tb.sv
